[design/vvet_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package vvet_pkg;

  // Table geometry defaults.
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int ID_BITS_DEF     = 32;
  localparam int TARGET_BITS_DEF = 16;

  // A list query never returns more than this many words.
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = 7;

  // Operation codes.
  typedef enum logic [1:0] {
    CMD_PUBLISH = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_LATEST  = 2'd2,
    CMD_LIST    = 2'd3
  } cmd_t;

  // Status codes.
  localparam logic [1:0] ST_CONFIRMED = 2'd0;
  localparam logic [1:0] ST_CLEARED   = 2'd1;
  localparam logic [1:0] ST_STALE     = 2'd2;
  localparam logic [1:0] ST_OTHER     = 2'd3;

  // Request word.
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] evt_id;
    logic        has_target;
    logic [15:0] target_id;
    logic [31:0] seq_num;
    logic [47:0] wall_time;
    logic [1:0]  status_code;
    logic [6:0]  max_count;
  } req_t;

  // Result word.
  typedef struct packed {
    logic        accepted;
    logic        found;
    logic        full_res;
    logic [31:0] out_event_id;
    logic [15:0] out_target_id;
    logic [31:0] out_seq_num;
    logic [47:0] out_wall_time;
    logic [1:0]  out_status;
    logic        last;
  } res_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_DONE
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;
    logic rd;
    logic finish;
  } ctl_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic fill_zero;
    logic last_addr;
  } sts_t;

endpackage

`default_nettype wire

[design/versioned_event_evidence_table.sv]
`timescale 1ns / 1ps
`default_nettype none

// Event evidence table. A command word is taken when start is high and busy
// is low. Every command scans the filled slots one per clock through the
// table memory's single registered read port, then passes a wait state and
// a done state before busy drops; on an empty table it goes straight to the
// done state. Results come out on res, one word per cycle marked by done,
// and must be taken in that cycle: the receiver cannot stall them. The
// closing word appears in the first cycle with busy low again. A list
// query emits its matches while the scan runs and flags the final word
// with last. The table is empty after reset; slots past the fill count
// are never read.

module versioned_event_evidence_table
  import vvet_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  parameter int TARGET_BITS = TARGET_BITS_DEF
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  start,
  input  req_t req,
  output logic busy,
  output res_t res,
  output logic done
);

  ctl_t ctl;
  sts_t sts;

  vvet_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  vvet_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_BITS     (ID_BITS),
    .TARGET_BITS (TARGET_BITS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .ctl  (ctl),
    .sts  (sts),
    .res  (res),
    .done (done)
  );

endmodule

`default_nettype wire

[design/vvet_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module vvet_ctrl
  import vvet_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  start,
  input  sts_t sts,
  output ctl_t ctl,
  output logic busy
);

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = sts.fill_zero ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        if (sts.last_addr) state_next = S_WAIT;
      end
      S_WAIT: state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    case (state)
      S_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
      end
      S_SCAN:  ctl.rd = 1'b1;
      S_WAIT:  ctl = '0;
      S_DONE:  ctl.finish = 1'b1;
      default: ctl = '0;
    endcase
  end

endmodule

`default_nettype wire

[design/vvet_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module vvet_dp
  import vvet_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  parameter int TARGET_BITS = TARGET_BITS_DEF
) (
  input  wire  clk,
  input  wire  rst,
  input  req_t req,
  input  ctl_t ctl,
  output sts_t sts,
  output res_t res,
  output logic done
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FW = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    logic [ID_BITS-1:0]     id;
    logic                   has;
    logic [TARGET_BITS-1:0] tgt;
    logic [31:0]            seq;
    logic [47:0]            wall;
    logic [1:0]             st;
    logic                   clr;
    logic                   ihas;
    logic [TARGET_BITS-1:0] itgt;
  } entry_t;

  entry_t mem [TABLE_DEPTH];

  // Latched request.
  cmd_t                   cmd_r;
  logic [ID_BITS-1:0]     id_r;
  logic                   has_r;
  logic [TARGET_BITS-1:0] tgt_r;
  logic [31:0]            seq_r;
  logic [47:0]            wall_r;
  logic [1:0]             st_r;
  logic [CNT_W-1:0]       cap_r;

  logic [FW-1:0]    fill;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    q_idx;
  logic             q_valid;
  entry_t           mem_q;
  entry_t           hold_e;
  logic             hold_v;
  logic [AW-1:0]    hold_idx;
  logic [CNT_W-1:0] count;

  logic   match, elig, take;
  logic   emit_scan;
  logic   newer, pub_ok;
  logic   wr_en;
  logic   fill_inc;
  logic [AW-1:0] wr_addr;
  entry_t wr_data;
  res_t   res_next;
  logic   done_next;

  function automatic res_t entry_res(entry_t e, logic lst);
    res_t r;
    r               = '0;
    r.found         = 1'b1;
    r.out_event_id  = 32'(e.id);
    r.out_target_id = e.has ? 16'(e.tgt) : 16'd0;
    r.out_seq_num   = e.seq;
    r.out_wall_time = e.wall;
    r.out_status    = e.st;
    r.last          = lst;
    return r;
  endfunction

  assign sts.fill_zero = (fill == '0);
  assign sts.last_addr = (rd_addr == AW'(fill - FW'(1)));

  // Per-entry evaluation of the registered read data.
  assign match = (mem_q.id == id_r);
  assign elig  = mem_q.ihas && (mem_q.itgt == tgt_r) && !mem_q.clr &&
                 ((mem_q.st == ST_CONFIRMED) || (mem_q.st == ST_OTHER));

  always_comb begin
    take      = 1'b0;
    emit_scan = 1'b0;
    if (q_valid) begin
      case (cmd_r)
        CMD_PUBLISH, CMD_CLEAR: take = match;
        CMD_LATEST: take = elig && (!hold_v || (mem_q.seq >= hold_e.seq));
        CMD_LIST: begin
          take      = elig && (count < cap_r);
          emit_scan = take && hold_v;
        end
        default: take = 1'b0;
      endcase
    end
  end

  // Final decision: table update and closing result.
  assign newer  = (seq_r > hold_e.seq) || ((seq_r == hold_e.seq) && (wall_r >= hold_e.wall));
  assign pub_ok = newer && !((hold_e.st == ST_CONFIRMED) && (st_r == ST_CLEARED));

  always_comb begin
    wr_en     = 1'b0;
    fill_inc  = 1'b0;
    wr_addr   = hold_idx;
    wr_data   = hold_e;
    res_next  = '0;
    done_next = 1'b0;
    if (emit_scan) begin
      res_next  = entry_res(hold_e, 1'b0);
      done_next = 1'b1;
    end
    if (ctl.finish) begin
      done_next     = 1'b1;
      res_next      = '0;
      res_next.last = 1'b1;
      case (cmd_r)
        CMD_PUBLISH: begin
          wr_data.has  = has_r;
          wr_data.tgt  = tgt_r;
          wr_data.seq  = seq_r;
          wr_data.wall = wall_r;
          wr_data.st   = st_r;
          wr_data.clr  = (st_r == ST_CLEARED);
          if (hold_v) begin
            wr_en             = pub_ok;
            res_next.accepted = pub_ok;
          end else if (fill == FW'(TABLE_DEPTH)) begin
            res_next.full_res = 1'b1;
          end else begin
            wr_en             = 1'b1;
            fill_inc          = 1'b1;
            wr_addr           = AW'(fill);
            wr_data.id        = id_r;
            wr_data.ihas      = has_r;
            wr_data.itgt      = has_r ? tgt_r : '0;
            res_next.accepted = 1'b1;
          end
        end
        CMD_CLEAR: begin
          wr_en          = hold_v;
          wr_data.clr    = 1'b1;
          res_next.found = hold_v;
        end
        CMD_LATEST, CMD_LIST: begin
          if (hold_v) res_next = entry_res(hold_e, 1'b1);
        end
        default: res_next = '0;
      endcase
    end
  end

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    mem_q <= mem[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      rd_addr <= '0;
      q_valid <= 1'b0;
      hold_v  <= 1'b0;
      count   <= '0;
      done    <= 1'b0;
    end else begin
      q_valid <= ctl.rd;
      done    <= done_next;
      if (fill_inc) fill <= fill + FW'(1);
      if (ctl.load) begin
        rd_addr <= '0;
        hold_v  <= 1'b0;
        count   <= '0;
      end else begin
        if (ctl.rd) rd_addr <= rd_addr + AW'(1);
        if (take) begin
          hold_v <= 1'b1;
          count  <= count + CNT_W'(1);
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    q_idx <= rd_addr;
    res   <= res_next;
    if (take) begin
      hold_e   <= mem_q;
      hold_idx <= q_idx;
    end
    if (ctl.load) begin
      cmd_r  <= req.cmd;
      id_r   <= ID_BITS'(req.evt_id);
      has_r  <= req.has_target;
      tgt_r  <= TARGET_BITS'(req.target_id);
      seq_r  <= req.seq_num;
      wall_r <= req.wall_time;
      st_r   <= req.status_code;
      cap_r  <= (req.max_count > CNT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : req.max_count;
    end
  end

endmodule

`default_nettype wire

[design/vvet_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module vvet_checker
  import vvet_pkg::*;
(
  input wire  clk,
  input wire  rst,
  input wire  start,
  input req_t req,
  input wire  busy,
  input res_t res,
  input wire  done
);

  // An accepted command makes the block busy.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after start");

  // A result word only follows a cycle of work.
  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result word without work");

  // Only list matches come without last, and they carry an entry.
  a_notlast: assert property (@(posedge clk) disable iff (rst)
    done && !res.last |-> res.found && !res.accepted && !res.full_res)
    else $error("non-final word is not a list match");

  // Publish never both stores and reports full.
  a_accfull: assert property (@(posedge clk) disable iff (rst)
    done |-> !(res.accepted && res.full_res)) else $error("accepted and full");

endmodule

bind versioned_event_evidence_table vvet_checker u_vvet_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .req   (req),
  .busy  (busy),
  .res   (res),
  .done  (done)
);

`default_nettype wire

[dv/versioned_event_evidence_table_test.sv]
`timescale 1ns / 1ps

module versioned_event_evidence_table_test;
  import vvet_pkg::*;

  localparam int DEPTH = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  res_t res;
  logic done;

  versioned_event_evidence_table i_dut (
    .clk(clk), .rst(rst), .start(start), .req(req), .busy(busy), .res(res), .done(done)
  );

  always #4 clk = ~clk;

  // Shadow copy of the evidence table.
  logic        tbl_valid [DEPTH];
  logic [31:0] tbl_id [DEPTH];
  logic        tbl_has [DEPTH];
  logic [15:0] tbl_tgt [DEPTH];
  logic [31:0] tbl_seq [DEPTH];
  logic [47:0] tbl_wall [DEPTH];
  logic [1:0]  tbl_status [DEPTH];
  logic        tbl_cleared [DEPTH];
  logic        idx_has [DEPTH];
  logic [15:0] idx_tgt [DEPTH];
  int          fill_cnt;

  res_t expected_words[$];
  int   fail_cnt;
  int   word_cnt;
  int   item_cnt;
  int   pub_cnt, clr_cnt, latest_cnt, list_cnt, full_cnt;

  // Result word carrying one table entry.
  function automatic res_t entry_word(int s, logic lst);
    res_t r;
    r = '0;
    r.found = 1'b1;
    r.out_event_id = tbl_id[s];
    r.out_target_id = tbl_has[s] ? tbl_tgt[s] : 16'd0;
    r.out_seq_num = tbl_seq[s];
    r.out_wall_time = tbl_wall[s];
    r.out_status = tbl_status[s];
    r.last = lst;
    return r;
  endfunction

  // Append one expected word at the tail of the queue.
  function automatic void queue_word(res_t r);
    expected_words.insert(expected_words.size(), r);
  endfunction

  function automatic int lookup_id(logic [31:0] id);
    for (int i = 0; i < fill_cnt; i++)
      if (tbl_valid[i] && tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic bit is_live(int i, logic [15:0] tgt);
    return tbl_valid[i] && idx_has[i] && idx_tgt[i] == tgt && !tbl_cleared[i] &&
           tbl_status[i] != ST_CLEARED && tbl_status[i] != ST_STALE;
  endfunction

  function automatic void store_entry(int s, req_t q);
    tbl_has[s] = q.has_target;
    tbl_tgt[s] = q.target_id;
    tbl_seq[s] = q.seq_num;
    tbl_wall[s] = q.wall_time;
    tbl_status[s] = q.status_code;
    tbl_cleared[s] = (q.status_code == ST_CLEARED);
  endfunction

  // Work out the words a command causes and update the shadow table.
  function automatic void predict_evidence(req_t q);
    res_t r;
    int s, best, n, cap;
    r = '0;
    r.last = 1'b1;
    case (q.cmd)
      CMD_PUBLISH: begin
        s = lookup_id(q.evt_id);
        if (s >= 0) begin
          if ((q.seq_num > tbl_seq[s] ||
               (q.seq_num == tbl_seq[s] && q.wall_time >= tbl_wall[s])) &&
              !(tbl_status[s] == ST_CONFIRMED && q.status_code == ST_CLEARED)) begin
            store_entry(s, q);
            r.accepted = 1'b1;
          end
        end else if (fill_cnt >= DEPTH) begin
          r.full_res = 1'b1;
          full_cnt++;
        end else begin
          s = fill_cnt;
          tbl_valid[s] = 1'b1;
          tbl_id[s] = q.evt_id;
          idx_has[s] = q.has_target;
          idx_tgt[s] = q.has_target ? q.target_id : 16'd0;
          store_entry(s, q);
          fill_cnt++;
          r.accepted = 1'b1;
        end
        queue_word(r);
      end
      CMD_CLEAR: begin
        s = lookup_id(q.evt_id);
        if (s >= 0) begin
          tbl_cleared[s] = 1'b1;
          r.found = 1'b1;
        end
        queue_word(r);
      end
      CMD_LATEST: begin
        best = -1;
        for (int i = 0; i < fill_cnt; i++)
          if (is_live(i, q.target_id) && (best < 0 || tbl_seq[i] >= tbl_seq[best]))
            best = i;
        queue_word(best >= 0 ? entry_word(best, 1'b1) : r);
      end
      default: begin
        cap = q.max_count > 64 ? 64 : q.max_count;
        n = 0;
        for (int i = 0; i < fill_cnt && n < cap; i++)
          if (is_live(i, q.target_id)) begin
            queue_word(entry_word(i, 1'b0));
            n++;
          end
        if (n == 0) queue_word(r);
        else expected_words[$].last = 1'b1;
      end
    endcase
  endfunction

  // Send one command word after a random gap. With no gap, start stays high
  // from the previous command and only the word changes.
  task automatic send_word(req_t q, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      req <= '0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_evidence(q);
    item_cnt++;
    case (q.cmd)
      CMD_PUBLISH: pub_cnt++;
      CMD_CLEAR: clr_cnt++;
      CMD_LATEST: latest_cnt++;
      default: list_cnt++;
    endcase
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    req <= '0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
  endtask

  function automatic req_t make_req(cmd_t c, logic [31:0] id, logic has, logic [15:0] tgt,
                                    logic [31:0] seq, logic [47:0] wall, logic [1:0] st,
                                    logic [6:0] mc);
    req_t q;
    q.cmd = c; q.evt_id = id; q.has_target = has; q.target_id = tgt;
    q.seq_num = seq; q.wall_time = wall; q.status_code = st; q.max_count = mc;
    return q;
  endfunction

  // Checker: every strobed word is compared with the oldest expectation.
  always @(posedge clk) begin
    res_t e;
    if (!rst && done) begin
      word_cnt++;
      if (expected_words.size() == 0) begin
        $error("unexpected word %h", res);
        fail_cnt++;
      end else begin
        e = expected_words.pop_front();
        if (res.accepted !== e.accepted) begin
          $error("accepted exp %0d got %0d", e.accepted, res.accepted); fail_cnt++; end
        if (res.found !== e.found) begin
          $error("found exp %0d got %0d", e.found, res.found); fail_cnt++; end
        if (res.full_res !== e.full_res) begin
          $error("full_res exp %0d got %0d", e.full_res, res.full_res); fail_cnt++; end
        if (res.out_event_id !== e.out_event_id) begin
          $error("out_event_id exp %h got %h", e.out_event_id, res.out_event_id);
          fail_cnt++;
        end
        if (res.out_target_id !== e.out_target_id) begin
          $error("out_target_id exp %h got %h", e.out_target_id, res.out_target_id);
          fail_cnt++;
        end
        if (res.out_seq_num !== e.out_seq_num) begin
          $error("out_seq_num exp %h got %h", e.out_seq_num, res.out_seq_num);
          fail_cnt++;
        end
        if (res.out_wall_time !== e.out_wall_time) begin
          $error("out_wall_time exp %h got %h", e.out_wall_time, res.out_wall_time);
          fail_cnt++;
        end
        if (res.out_status !== e.out_status) begin
          $error("out_status exp %0d got %0d", e.out_status, res.out_status); fail_cnt++; end
        if (res.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, res.last); fail_cnt++; end
      end
    end
  end

  // Directed: version ordering, clear rules, empty and capped queries.
  task automatic test_directed();
    send_word(make_req(CMD_LATEST, 32'd0, 1'b0, 16'hFFFF, '0, '0, ST_CONFIRMED, 7'd0));
    send_word(make_req(CMD_LIST, 32'd0, 1'b0, 16'h0, '0, '0, ST_CONFIRMED, 7'd64));
    send_word(make_req(CMD_CLEAR, 32'hFFFF_FFFF, 1'b0, '0, '0, '0, ST_CONFIRMED, 7'd0));
    send_word(make_req(CMD_PUBLISH, 32'd0, 1'b1, 16'h0, 32'd5, 48'd100, ST_CONFIRMED, 0));
    send_word(make_req(CMD_PUBLISH, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF,
                       48'hFFFF_FFFF_FFFF, ST_OTHER, 7'h7F));
    // Older sequence, equal sequence with older and equal wall time.
    send_word(make_req(CMD_PUBLISH, 32'd0, 1'b1, 16'h0, 32'd4, 48'd999, ST_OTHER, 0));
    send_word(make_req(CMD_PUBLISH, 32'd0, 1'b1, 16'h0, 32'd5, 48'd99, ST_OTHER, 0));
    send_word(make_req(CMD_PUBLISH, 32'd0, 1'b1, 16'h0, 32'd5, 48'd100, ST_CONFIRMED, 0));
    // A newer cleared event does not replace a confirmed one.
    send_word(make_req(CMD_PUBLISH, 32'd0, 1'b1, 16'h0, 32'd9, 48'd0, ST_CLEARED, 0));
    // Replacement under another target keeps the index target.
    send_word(make_req(CMD_PUBLISH, 32'd0, 1'b1, 16'h7, 32'd9, 48'd0, ST_OTHER, 0));
    send_word(make_req(CMD_PUBLISH, 32'd1, 1'b1, 16'h0, 32'd9, 48'd1, ST_CONFIRMED, 0));
    send_word(make_req(CMD_PUBLISH, 32'd2, 1'b1, 16'h0, 32'd3, 48'd1, ST_STALE, 0));
    send_word(make_req(CMD_PUBLISH, 32'd3, 1'b0, 16'h0, 32'd20, 48'd1, ST_CONFIRMED, 0));
    send_word(make_req(CMD_LATEST, 32'd0, 1'b0, 16'h0, '0, '0, ST_CONFIRMED, 0));
    send_word(make_req(CMD_LIST, 32'd0, 1'b0, 16'h0, '0, '0, ST_CONFIRMED, 7'd64));
    send_word(make_req(CMD_LIST, 32'd0, 1'b0, 16'h0, '0, '0, ST_CONFIRMED, 7'd1));
    send_word(make_req(CMD_LIST, 32'd0, 1'b0, 16'h0, '0, '0, ST_CONFIRMED, 7'd0));
    send_word(make_req(CMD_LIST, 32'd0, 1'b0, 16'h0, '0, '0, ST_CONFIRMED, 7'h7F));
    send_word(make_req(CMD_CLEAR, 32'd1, 1'b0, '0, '0, '0, ST_CONFIRMED, 0));
    send_word(make_req(CMD_LATEST, 32'd0, 1'b0, 16'h0, '0, '0, ST_CONFIRMED, 0));
    send_word(make_req(CMD_LATEST, 32'd0, 1'b0, 16'hFFFF, '0, '0, ST_CONFIRMED, 0));
    send_word(make_req(CMD_LIST, 32'd0, 1'b0, 16'h7, '0, '0, ST_CONFIRMED, 7'd64));
    wait_drained();
  endtask

  // Random traffic over a small id and target pool so entries collide.
  task automatic test_random(int count);
    req_t q;
    for (int k = 0; k < count; k++) begin
      q.cmd = cmd_t'($urandom_range(0, 3));
      if ($urandom_range(0, 1)) q.cmd = CMD_PUBLISH;
      q.evt_id = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 90));
      q.has_target = $urandom_range(0, 4) != 0;
      q.target_id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      q.seq_num = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 8));
      q.wall_time = ($urandom_range(0, 9) == 0) ? {16'($urandom), 32'($urandom)}
                                                 : 48'($urandom_range(0, 4));
      q.status_code = 2'($urandom_range(0, 3));
      q.max_count = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 70));
      send_word(q, $urandom_range(0, 3) == 0);
      if (k == count / 2) wait_drained();
    end
  endtask

  // Overflow: fill every slot, then a fresh id must be refused.
  task automatic test_full();
    for (int i = fill_cnt; i <= DEPTH + 1; i++)
      send_word(make_req(CMD_PUBLISH, 32'h8000_0000 + i, 1'b1, 16'h5, i, 48'd0,
                         ST_CONFIRMED, 0), 1);
    send_word(make_req(CMD_LIST, 32'd0, 1'b0, 16'h5, '0, '0, ST_CONFIRMED, 7'd64));
    send_word(make_req(CMD_PUBLISH, 32'd0, 1'b1, 16'h0, 32'hFFFF_FFFF,
                       48'hFFFF_FFFF_FFFF, ST_OTHER, 0));
    test_random(60);
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      tbl_valid[i] = 0; tbl_id[i] = 0; tbl_has[i] = 0; tbl_tgt[i] = 0; tbl_seq[i] = 0;
      tbl_wall[i] = 0; tbl_status[i] = 0; tbl_cleared[i] = 0; idx_has[i] = 0;
      idx_tgt[i] = 0;
    end
    fill_cnt = 0; fail_cnt = 0; word_cnt = 0; item_cnt = 0;
    pub_cnt = 0; clr_cnt = 0; latest_cnt = 0; list_cnt = 0; full_cnt = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(230);
    test_full();
    wait_drained();
    if (expected_words.size() != 0) begin
      $error("%0d words never arrived", expected_words.size());
      fail_cnt++;
    end
    $display("Sent %0d commands (%0d publish, %0d clear, %0d latest, %0d list).",
             item_cnt, pub_cnt, clr_cnt, latest_cnt, list_cnt);
    $display("Checked %0d result words; %0d publishes hit a full table.", word_cnt, full_cnt);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
